>>> hdl/ddlcs_pkg.sv
// Shared constants and control structs for the deletion distance block.
package ddlcs_pkg;

  localparam int REQ_W    = 2;
  localparam int SYM_W    = 8;
  localparam int DIST_W   = 10;
  localparam int COMMON_W = 9;

  localparam logic [REQ_W-1:0] REQ_FIRST   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SECOND  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

  localparam logic [DIST_W-1:0]   DIST_MAX   = 10'd1023;
  localparam logic [COMMON_W-1:0] COMMON_MAX = 9'd511;

  typedef struct packed {
    logic append_first;
    logic append_second;
    logic clear;
  } word_ctl_t;

  typedef struct packed {
    logic row_start;
    logic cell_en;
    logic first_row;
  } cell_ctl_t;

endpackage

>>> hdl/deletion_distance_lcs_top.sv
// Top level of the deletion distance block: request decode, sweep sequencer and result.
//
// Usage: a transaction is taken at a rising edge where start is high and busy is
// low. req_type REQ_FIRST or REQ_SECOND appends symbol to the first or second
// word and leaves busy low, so appends can stream one per cycle while busy is low.
// Symbols past MAX_LEN are dropped and flagged in overflow.
// A compute transaction raises busy while the score row memory is swept: one
// row pass per symbol of the first word, one cell per cycle, plus a row fetch
// state before each row to fetch that symbol. With both words nonempty, done goes
// high from the finish state after the last row; with either word empty the
// sweep is skipped and done goes high from the finish state. The row memory's
// single write port sets the pace.
// done is high for exactly one cycle with distance, common_length and overflow;
// busy is already low in that cycle. The receiver cannot stall the result.
// After compute both words are empty and the internal overflow flag is cleared. Unused request
// codes are accepted and do nothing.
// Reset (rst, synchronous, active high) empties both words and clears the internal overflow
// flag (the overflow output keeps its value until the next done); no clearing pass of the memories is needed.
module deletion_distance_lcs_top #(
  parameter int MAX_LEN = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [ddlcs_pkg::REQ_W-1:0]    req_type,
  input  logic [ddlcs_pkg::SYM_W-1:0]    symbol,
  output logic                           done,
  output logic [ddlcs_pkg::DIST_W-1:0]   distance,
  output logic [ddlcs_pkg::COMMON_W-1:0] common_length,
  output logic                           overflow
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int DW = CW + 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ROW    = 2'd1;
  localparam logic [1:0] S_CELL   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]    state;
  logic [AW-1:0] i;
  logic [AW-1:0] wj;
  logic [CW-1:0] lcs;

  logic                        accept;
  ddlcs_pkg::word_ctl_t        word_ctl;
  ddlcs_pkg::cell_ctl_t        cell_ctl;
  logic [AW-1:0]               rd_addr;
  logic [ddlcs_pkg::SYM_W-1:0] a_sym;
  logic [ddlcs_pkg::SYM_W-1:0] b_sym;
  logic [CW-1:0]               first_count;
  logic [CW-1:0]               second_count;
  logic                        ovf_seen;
  logic [CW-1:0]               value;
  logic                        row_last;
  logic                        i_last;
  logic [DW-1:0]               dist_sum;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign word_ctl.append_first  = accept && (req_type == ddlcs_pkg::REQ_FIRST);
  assign word_ctl.append_second = accept && (req_type == ddlcs_pkg::REQ_SECOND);
  assign word_ctl.clear         = (state == S_FINISH);

  assign cell_ctl.row_start = (state == S_ROW);
  assign cell_ctl.cell_en   = (state == S_CELL);
  assign cell_ctl.first_row = (i == '0);

  // The read runs one cell ahead of the write; the row fetch cycle starts at cell zero.
  assign rd_addr  = (state == S_ROW) ? '0 : wj + AW'(1);
  assign row_last = (CW'(wj) == second_count - CW'(1));
  assign i_last   = (CW'(i) == first_count - CW'(1));

  assign dist_sum = DW'(first_count) + DW'(second_count) - (DW'(lcs) << 1);

  ddlcs_words #(
    .MAX_LEN (MAX_LEN),
    .AW      (AW),
    .CW      (CW)
  ) u_words (
    .clk          (clk),
    .rst          (rst),
    .ctl          (word_ctl),
    .symbol       (symbol),
    .first_addr   (i),
    .second_addr  (rd_addr),
    .first_sym    (a_sym),
    .second_sym   (b_sym),
    .first_count  (first_count),
    .second_count (second_count),
    .ovf_seen     (ovf_seen)
  );

  ddlcs_row #(
    .MAX_LEN (MAX_LEN),
    .AW      (AW),
    .SW      (CW)
  ) u_row (
    .clk     (clk),
    .ctl     (cell_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wj),
    .a_sym   (a_sym),
    .b_sym   (b_sym),
    .value   (value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && (req_type == ddlcs_pkg::REQ_COMPUTE)) begin
            if ((first_count == '0) || (second_count == '0)) begin
              lcs   <= '0;
              state <= S_FINISH;
            end else begin
              i     <= '0;
              state <= S_ROW;
            end
          end
        end
        S_ROW: begin
          wj    <= '0;
          state <= S_CELL;
        end
        S_CELL: begin
          if (row_last) begin
            if (i_last) begin
              lcs   <= value;
              state <= S_FINISH;
            end else begin
              i     <= i + AW'(1);
              state <= S_ROW;
            end
          end else begin
            wj <= wj + AW'(1);
          end
        end
        S_FINISH: begin
          if (32'(dist_sum) > 32'(ddlcs_pkg::DIST_MAX)) begin
            distance <= ddlcs_pkg::DIST_MAX;
          end else begin
            distance <= ddlcs_pkg::DIST_W'(dist_sum);
          end
          if (32'(lcs) > 32'(ddlcs_pkg::COMMON_MAX)) begin
            common_length <= ddlcs_pkg::COMMON_MAX;
          end else begin
            common_length <= ddlcs_pkg::COMMON_W'(lcs);
          end
          overflow <= ovf_seen;
          done     <= 1'b1;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/ddlcs_words.sv
// Symbol memories for both words, their fill counts and the overflow flag.
module ddlcs_words #(
  parameter int MAX_LEN = 256,
  parameter int AW      = 8,
  parameter int CW      = 9
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ddlcs_pkg::word_ctl_t         ctl,
  input  logic [ddlcs_pkg::SYM_W-1:0]  symbol,
  input  logic [AW-1:0]                first_addr,
  input  logic [AW-1:0]                second_addr,
  output logic [ddlcs_pkg::SYM_W-1:0]  first_sym,
  output logic [ddlcs_pkg::SYM_W-1:0]  second_sym,
  output logic [CW-1:0]                first_count,
  output logic [CW-1:0]                second_count,
  output logic                         ovf_seen
);

  localparam logic [CW-1:0] FULL = CW'(MAX_LEN);

  logic [ddlcs_pkg::SYM_W-1:0] first_mem  [MAX_LEN];
  logic [ddlcs_pkg::SYM_W-1:0] second_mem [MAX_LEN];

  logic first_full;
  logic second_full;

  assign first_full  = (first_count == FULL);
  assign second_full = (second_count == FULL);

  always_ff @(posedge clk) begin
    if (ctl.append_first && !first_full) begin
      first_mem[first_count[AW-1:0]] <= symbol;
    end
    first_sym <= first_mem[first_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.append_second && !second_full) begin
      second_mem[second_count[AW-1:0]] <= symbol;
    end
    second_sym <= second_mem[second_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      first_count  <= '0;
      second_count <= '0;
      ovf_seen     <= 1'b0;
    end else begin
      if (ctl.append_first) begin
        if (first_full) begin
          ovf_seen <= 1'b1;
        end else begin
          first_count <= first_count + CW'(1);
        end
      end
      if (ctl.append_second) begin
        if (second_full) begin
          ovf_seen <= 1'b1;
        end else begin
          second_count <= second_count + CW'(1);
        end
      end
    end
  end

endmodule

>>> hdl/ddlcs_row.sv
// Score row memory and the recurrence cell that updates it one entry a cycle while cell_en is high.
module ddlcs_row #(
  parameter int MAX_LEN = 256,
  parameter int AW      = 8,
  parameter int SW      = 9
) (
  input  logic                        clk,
  input  ddlcs_pkg::cell_ctl_t        ctl,
  input  logic [AW-1:0]               rd_addr,
  input  logic [AW-1:0]               wr_addr,
  input  logic [ddlcs_pkg::SYM_W-1:0] a_sym,
  input  logic [ddlcs_pkg::SYM_W-1:0] b_sym,
  output logic [SW-1:0]               value
);

  logic [SW-1:0] score_mem [MAX_LEN];
  logic [SW-1:0] rd_data;
  logic [SW-1:0] up;
  logic [SW-1:0] diag;
  logic [SW-1:0] left;

  // The first row sees an all-zero row above it, so no clearing pass is needed.
  assign up = ctl.first_row ? '0 : rd_data;

  always_comb begin
    if (a_sym == b_sym) begin
      value = diag + SW'(1);
    end else if (up > left) begin
      value = up;
    end else begin
      value = left;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cell_en) begin
      score_mem[wr_addr] <= value;
    end
    rd_data <= score_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.row_start) begin
      diag <= '0;
      left <= '0;
    end else if (ctl.cell_en) begin
      diag <= up;
      left <= value;
    end
  end

endmodule
